>>> sv/assert_macros.svh
// Assertion macros used by the checker file wca_checker.sv.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WCA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define WCA_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/wca_pkg.sv
// Package for the window coefficient block: payload structs, codes and sizes.
// Used by the controller, the datapath, the top level and the checker.
package wca_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int LENGTH_W     = 12;
   localparam int TYPE_W       = 2;
   localparam int PHASE_W      = 16;
   localparam int DVD_W        = LENGTH_W + PHASE_W;
   localparam int DIV_STEPS    = DVD_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = LENGTH_W;
   localparam int COS_W        = 18;
   localparam int COEFF_W      = 17;

   localparam int DEF_MAX_LENGTH     = 4095;
   localparam int DEF_COS_TABLE_BITS = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TYPE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 1'b1;

   typedef enum logic [TYPE_W-1:0] {
      WIN_RECT     = 2'd0,
      WIN_HAMMING  = 2'd1,
      WIN_HANN     = 2'd2,
      WIN_BLACKMAN = 2'd3
   } window_kind_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] windowed_sample;
      logic                       last_out;
      logic                       length_mismatch;
      logic                       invalid_length;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_COS_A,
      ST_COS_B,
      ST_PROD,
      ST_COEF,
      ST_SMUL,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic cos_a;
      logic cos_b;
      logic prod;
      logic coef;
      logic smul;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

>>> sv/window_coefficient_apply_core.sv
// Window coefficient block: multiplies each sample of a frame by a rectangular,
// Hamming, Hann or Blackman coefficient picked by its position in the frame.
// Channels: req_* carries one sample and its frame_end flag per transaction;
// rsp_* returns one windowed sample with last_out, length_mismatch and
// invalid_length flags. Both use valid/ready. csr_* writes window_type
// (index 0) and window_length (index 1); the user must write them only
// while the block is idle, as the block itself does not enforce it. The phase
// n*65536/(N-1) comes from a restoring divider that yields one quotient bit
// per cycle, followed by two cosine ROM reads on a single port, the coefficient
// products, the coefficient sum, the sample product and the output load. One
// transaction is in flight at a time: a new sample is taken only after the
// last result has been loaded into the output register.
// The output register lets a new request be taken while a result waits; if
// the receiver stalls, the next result holds in the datapath until the
// output register frees, and no new request is taken meanwhile.
// Reset (synchronous, active high) selects the rectangular window, length 3,
// and restarts the frame position at 0.
module window_coefficient_apply_core
   import wca_pkg::*;
#(
   parameter int MAX_LENGTH     = DEF_MAX_LENGTH,
   parameter int COS_TABLE_BITS = DEF_COS_TABLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   wca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wca_datapath #(
      .MAX_LENGTH     (MAX_LENGTH),
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sv/wca_ctrl.sv
// Sequencer for the window coefficient block: input handshake and step order.
// Depends on wca_pkg; drives the datapath through dp_cmd_type.
module wca_ctrl
   import wca_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_COS_A;
            end
         end
         ST_COS_A: begin
            cmd.cos_a = 1'b1;
            state_in  = ST_COS_B;
         end
         ST_COS_B: begin
            cmd.cos_b = 1'b1;
            state_in  = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_COEF;
         end
         ST_COEF: begin
            cmd.coef = 1'b1;
            state_in = ST_SMUL;
         end
         ST_SMUL: begin
            cmd.smul = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> sv/wca_datapath.sv
// Datapath: registers, index tracking, phase divider, cosine ROM, coefficient
// arithmetic and output register. Depends on wca_pkg; steered by wca_ctrl.
module wca_datapath
   import wca_pkg::*;
#(
   parameter int MAX_LENGTH     = DEF_MAX_LENGTH,
   parameter int COS_TABLE_BITS = DEF_COS_TABLE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  req_type                 req_data,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data
);

   localparam int TAB_SIZE = 1 << COS_TABLE_BITS;
   localparam logic [63:0] Q62_ONE     = 64'h4000000000000000;
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

   typedef logic signed [COS_W-1:0] cos_tab_type [TAB_SIZE];

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   function automatic logic [63:0] quarter_cos(input int j);
      logic [63:0] x, x2, term, sum;
      x    = (HALF_PI_Q62 >> (COS_TABLE_BITS - 2)) * 64'(j);
      x2   = mul_q62(x, x);
      term = Q62_ONE;
      sum  = Q62_ONE;
      for (int k = 1; k <= 14; k++) begin
         term = mul_q62(term, x2) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) sum = sum - term;
         else            sum = sum + term;
      end
      if (sum > (64'd3 << 62)) sum = '0;
      return (sum + (64'd1 << 45)) >> 46;
   endfunction

   function automatic cos_tab_type build_tab();
      cos_tab_type t;
      int          q;
      logic [63:0] v;
      q = TAB_SIZE / 4;
      for (int k = 0; k < TAB_SIZE; k++) begin
         if (k <= q) begin
            v = quarter_cos(k);
            t[k] = COS_W'(v);
         end else if (k <= 2 * q) begin
            v = quarter_cos(2 * q - k);
            t[k] = -COS_W'(v);
         end else if (k <= 3 * q) begin
            v = quarter_cos(k - 2 * q);
            t[k] = -COS_W'(v);
         end else begin
            v = quarter_cos(TAB_SIZE - k);
            t[k] = COS_W'(v);
         end
      end
      return t;
   endfunction

   localparam cos_tab_type COS_TAB = build_tab();

   // Configuration and frame position.
   window_kind_type         wtype_ff;
   logic [LENGTH_W-1:0]     wlen_ff;
   logic [LENGTH_W-1:0]     index_ff;

   // Per-transaction work registers.
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       last_ff, mismatch_ff, invalid_ff;
   logic [LENGTH_W-1:0]        divisor_ff;
   logic [LENGTH_W-1:0]        rem_ff;
   logic [DVD_W-1:0]           dvd_ff;
   logic signed [COS_W-1:0]    c_ff, c2_ff;
   logic signed [33:0]         p1_ff;
   logic signed [31:0]         p2_ff;
   logic [COEFF_W-1:0]         coeff_ff;
   logic signed [33:0]         sprod_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;

   logic [LENGTH_W-1:0]        last_idx;
   logic                       last_now, invalid_now;
   logic [LENGTH_W:0]          rem_shift;
   logic                       q_bit;
   logic [PHASE_W-1:0]         phase, phase2;
   logic [15:0]                k1;
   logic signed [34:0]         base, num;
   logic [COEFF_W-1:0]         coeff_calc;
   logic signed [33:0]         rounded;

   assign last_idx    = (wlen_ff == '0) ? '0 : wlen_ff - 1'b1;
   assign last_now    = index_ff >= last_idx;
   assign invalid_now = (wlen_ff < LENGTH_W'(3)) || !wlen_ff[0]
                        || (int'(wlen_ff) > MAX_LENGTH);

   // One restoring division step; quotient bits shift into the dividend.
   assign rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
   assign q_bit     = rem_shift >= {1'b0, divisor_ff};

   assign phase  = dvd_ff[PHASE_W-1:0];
   assign phase2 = {phase[PHASE_W-2:0], 1'b0};

   always_comb begin
      k1   = (wtype_ff == WIN_HAMMING) ? 16'd30147 : 16'd32768;
      base = 35'sd0;
      num  = 35'sd0;
      case (wtype_ff)
         WIN_HAMMING:  base = 35'sd35389 * 35'sd65536;
         WIN_HANN:     base = 35'sd32768 * 35'sd65536;
         WIN_BLACKMAN: base = 35'sd27525 * 35'sd65536;
         default:      base = 35'sd0;
      endcase
      num = base - 35'(p1_ff) + 35'sd32768;
      if (wtype_ff == WIN_BLACKMAN) num = num + 35'(p2_ff);
      if (wtype_ff == WIN_RECT) begin
         coeff_calc = COEFF_W'(65536);
      end else if (num < 0) begin
         coeff_calc = '0;
      end else if (num[34:16] > 19'sd65536) begin
         coeff_calc = COEFF_W'(65536);
      end else begin
         coeff_calc = num[16+COEFF_W-1:16];
      end
   end

   assign rounded = sprod_ff + 34'sd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         wtype_ff     <= WIN_RECT;
         wlen_ff      <= LENGTH_W'(3);
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_WINDOW_TYPE:   wtype_ff <= window_kind_type'(csr_wdata[TYPE_W-1:0]);
               CSR_WINDOW_LENGTH: wlen_ff  <= csr_wdata[LENGTH_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            index_ff <= (last_now || req_data.frame_end) ? '0 : index_ff + 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff   <= req_data.sample;
         last_ff     <= last_now;
         mismatch_ff <= last_now != req_data.frame_end;
         invalid_ff  <= invalid_now;
         divisor_ff  <= last_idx;
         rem_ff      <= '0;
         dvd_ff      <= {index_ff, PHASE_W'(0)};
      end
      if (cmd.div_step) begin
         rem_ff <= q_bit ? LENGTH_W'(rem_shift - {1'b0, divisor_ff})
                         : rem_shift[LENGTH_W-1:0];
         dvd_ff <= {dvd_ff[DVD_W-2:0], q_bit};
      end
      if (cmd.cos_a) c_ff  <= COS_TAB[phase[PHASE_W-1 -: COS_TABLE_BITS]];
      if (cmd.cos_b) c2_ff <= COS_TAB[phase2[PHASE_W-1 -: COS_TABLE_BITS]];
      if (cmd.prod) begin
         p1_ff <= 34'(c_ff) * $signed({18'd0, k1});
         p2_ff <= 32'(c2_ff) * 32'sd5243;
      end
      if (cmd.coef) coeff_ff <= coeff_calc;
      if (cmd.smul) sprod_ff <= 34'(sample_ff) * $signed({17'd0, coeff_ff});
      if (cmd.emit) begin
         rsp_data_ff.windowed_sample <= invalid_ff ? '0 : rounded[31:16];
         rsp_data_ff.last_out        <= last_ff;
         rsp_data_ff.length_mismatch <= mismatch_ff;
         rsp_data_ff.invalid_length  <= invalid_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

>>> sv/wca_checker.sv
// Port-level checker for window_coefficient_apply_core, bound to the top level.
// Depends on wca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wca_checker
   import wca_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A result that is not taken stays offered.
   `WCA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // An invalid length always yields a zero sample.
   `WCA_ASSERT_IMP(a_invalid_zero, rsp_valid && rsp_data.invalid_length,
                   rsp_data.windowed_sample == '0)

   // Only one transaction is in flight: the block is busy right after accepting.
   `WCA_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // No result can appear in the cycle right after a request is accepted.
   `WCA_ASSERT_NXT(a_no_instant_rsp, req_valid && req_ready && !rsp_valid, !rsp_valid)

endmodule

bind window_coefficient_apply_core wca_checker u_wca_checker (.*);

>>> tb/sv/window_coefficient_apply_core_tb.sv
// Self-checking testbench for window_coefficient_apply_core: a directed table, then random
// frames over many window settings, with random stalls on both channels.
// Depends on wca_pkg and the core; its own predictor rebuilds the cosine table bit for bit.
module window_coefficient_apply_core_tb;
   import wca_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int ROM_SIZE      = 1 << DEF_COS_TABLE_BITS;
   localparam int ROM_QUARTER   = ROM_SIZE / 4;
   localparam longint unsigned Q62_ONE = 64'h4000_0000_0000_0000;
   localparam longint unsigned HALF_PI = 64'h6487_ED51_10B4_611A;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      req_type               item;
      logic                  typed;
      rsp_type               result;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Typed-in expectation riding along with the current request transaction.
   logic    typed_valid;
   rsp_type typed_result;

   int              cos_rom [ROM_SIZE];
   window_kind_type win_kind;
   logic [11:0]     win_length;
   logic [11:0]     frame_pos;
   rsp_type         pending_results [$];
   int              error_count;
   int              cycle_count;
   bit              stalls_on;
   bit              hold_request;
   stim_row_type    stim_rows [$];

   always #4 clock = ~clock;

   window_coefficient_apply_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return p[125:62];
   endfunction

   // Taylor series of cos over the first quadrant, in Q62, rounded to Q16.
   function automatic int quarter_cosine(int unsigned j);
      longint unsigned x, x2, term, total;
      x = (HALF_PI >> (DEF_COS_TABLE_BITS - 2)) * longint'(j);
      x2 = mul_q62(x, x);
      term = Q62_ONE;
      total = Q62_ONE;
      for (int k = 1; k <= 14; k++) begin
         term = mul_q62(term, x2) / longint'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) total = total - term;
         else total = total + term;
      end
      if (total > 3 * Q62_ONE) total = 0;
      return int'((total + (64'd1 << 45)) >> 46);
   endfunction

   function automatic longint cosine_at(logic [15:0] phase);
      return longint'(cos_rom[phase >> (16 - DEF_COS_TABLE_BITS)]);
   endfunction

   function automatic rsp_type window_sample(req_type r);
      rsp_type     res;
      logic [11:0] last_pos;
      logic [15:0] phase;
      longint      c, num, coeff, prod;
      bit          bad_len, at_last;
      last_pos = (win_length == 0) ? 12'd0 : win_length - 12'd1;
      bad_len = (win_length < 3) || !win_length[0];
      at_last = frame_pos >= last_pos;
      res = '0;
      if (!bad_len) begin
         phase = 16'((longint'(frame_pos) << 16) / longint'(last_pos));
         c = cosine_at(phase);
         case (win_kind)
            WIN_HAMMING:  num = 35389 * 65536 - 30147 * c + 32768;
            WIN_HANN:     num = 32768 * 65536 - 32768 * c + 32768;
            WIN_BLACKMAN: num = 27525 * 65536 - 32768 * c
                                + 5243 * cosine_at({phase[14:0], 1'b0}) + 32768;
            default:      num = 65536 * 65536;
         endcase
         coeff = (num < 0) ? 0 : (num >>> 16);
         if (coeff > 65536) coeff = 65536;
         prod = longint'(r.sample) * coeff + 32768;
         res.windowed_sample = 16'(prod >>> 16);
      end
      res.last_out = at_last;
      res.length_mismatch = at_last != r.frame_end;
      res.invalid_length = bad_len;
      frame_pos = (at_last || r.frame_end) ? 12'd0 : frame_pos + 12'd1;
      return res;
   endfunction

   initial begin
      for (int k = 0; k < ROM_SIZE; k++) begin
         if (k <= ROM_QUARTER) cos_rom[k] = quarter_cosine(k);
         else if (k <= 2 * ROM_QUARTER) cos_rom[k] = -quarter_cosine(2 * ROM_QUARTER - k);
         else if (k <= 3 * ROM_QUARTER) cos_rom[k] = -quarter_cosine(k - 2 * ROM_QUARTER);
         else cos_rom[k] = quarter_cosine(ROM_SIZE - k);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL window_coefficient_apply_core");
         $finish;
      end
   end

   // Scoreboard: predict on each accepted request, compare on each accepted result.
   always @(posedge clock) begin
      rsp_type want, got;
      if (reset) begin
         win_kind = WIN_RECT;
         win_length = 12'd3;
         frame_pos = 12'd0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (pending_results.size() == 0) begin
               $error("result transaction with no expectation waiting");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.windowed_sample !== want.windowed_sample) begin
                  $error("windowed_sample expected %0d actual %0d",
                         want.windowed_sample, got.windowed_sample);
                  error_count++;
               end
               if (got.last_out !== want.last_out) begin
                  $error("last_out expected %b actual %b", want.last_out, got.last_out);
                  error_count++;
               end
               if (got.length_mismatch !== want.length_mismatch) begin
                  $error("length_mismatch expected %b actual %b",
                         want.length_mismatch, got.length_mismatch);
                  error_count++;
               end
               if (got.invalid_length !== want.invalid_length) begin
                  $error("invalid_length expected %b actual %b",
                         want.invalid_length, got.invalid_length);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = window_sample(req_data);
            pending_results.push_back(typed_valid ? typed_result : want);
         end
         if (csr_we) begin
            if (csr_index == CSR_WINDOW_TYPE) win_kind = window_kind_type'(csr_wdata[1:0]);
            else if (csr_index == CSR_WINDOW_LENGTH) win_length = csr_wdata;
         end
      end
   end

   // Result side: random stall bursts, plus one long hold-off to back the core up.
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            for (int n = 0; n < 400; n++) @(posedge clock);
            hold_request = 1'b0;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_sample(req_type r, logic typed, rsp_type result);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      typed_valid <= typed;
      typed_result <= result;
      do @(posedge clock); while (!req_ready);
   endtask

   // Registers change only once every result is back and the core has settled.
   // The task first lets the clock tick so that the last accepted transaction is on the queue.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void add_write(logic [CSR_IDX_W-1:0] idx, int value);
      stim_row_type row;
      row = '{ROW_WRITE, idx, CSR_DATA_W'(value), '0, 1'b0, '0};
      stim_rows.push_back(row);
   endfunction

   function automatic void add_sample(int s, bit fe, bit typed = 0, int ws = 0,
                                      bit lo = 0, bit lm = 0, bit il = 0);
      stim_row_type row;
      row = '{ROW_SAMPLE, '0, '0, '{16'(s), fe}, typed, '{16'(ws), lo, lm, il}};
      stim_rows.push_back(row);
   endfunction

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      req_type         r;
      logic [11:0]     n_len, last_pos, pos;
      bit              fe;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      typed_valid = 1'b0;
      typed_result = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      error_count = 0;
      cycle_count = 0;
      stalls_on = 1'b1;
      hold_request = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // After reset: rectangular window of length 3, so samples pass unchanged.
      add_sample(32767, 0, 1, 32767, 0, 0, 0);
      add_sample(-32768, 0, 1, -32768, 0, 0, 0);
      add_sample(0, 1, 1, 0, 1, 0, 0);
      add_sample(1, 0, 1, 1, 0, 0, 0);
      add_sample(-1, 1, 1, -1, 0, 1, 0);
      // Even and too-short lengths force zero output and raise the flag.
      add_write(CSR_WINDOW_LENGTH, 4094);
      add_sample(1234, 0, 1, 0, 0, 0, 1);
      add_sample(-5, 1, 1, 0, 0, 1, 1);
      add_write(CSR_WINDOW_LENGTH, 0);
      add_sample(7, 0, 1, 0, 1, 1, 1);
      add_write(CSR_WINDOW_LENGTH, 2);
      add_sample(100, 0, 1, 0, 0, 0, 1);
      add_sample(100, 0, 1, 0, 1, 1, 1);
      add_write(CSR_WINDOW_LENGTH, 1);
      add_sample(-100, 1, 1, 0, 1, 0, 1);
      // Hann at the frame start has a zero coefficient.
      add_write(CSR_WINDOW_TYPE, WIN_HANN);
      add_write(CSR_WINDOW_LENGTH, 5);
      add_sample(32767, 0, 1, 0, 0, 0, 0);
      add_sample(-32768, 0);
      add_sample(32767, 0);
      add_sample(-32768, 0);
      add_sample(32767, 1);
      add_write(CSR_WINDOW_TYPE, WIN_HAMMING);
      add_write(CSR_WINDOW_LENGTH, 4095);
      add_sample(-32768, 0);
      add_sample(32767, 0);
      // Length lowered mid-frame leaves the index at the new end.
      add_write(CSR_WINDOW_LENGTH, 3);
      add_sample(32767, 0);
      add_write(CSR_WINDOW_TYPE, WIN_BLACKMAN);
      add_write(CSR_WINDOW_LENGTH, 7);
      for (int k = 0; k < 7; k++) add_sample(k[0] ? -32768 : 32767, k == 6);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_WRITE)
            write_register(stim_rows[i].reg_index, stim_rows[i].reg_value);
         else
            send_sample(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].result);
      end

      hold_request = 1'b1;
      for (int phase_no = 0; phase_no < 16; phase_no++) begin
         case ($urandom_range(0, 9))
            0: n_len = 12'd4095;
            1: n_len = 12'(2 * $urandom_range(0, 2047));
            2: n_len = 12'($urandom_range(0, 2));
            3: n_len = 12'($urandom_range(0, 4095));
            default: n_len = 12'(3 + 2 * $urandom_range(0, 30));
         endcase
         if (phase_no == 15) stalls_on = 1'b0;
         write_register(CSR_WINDOW_TYPE, CSR_DATA_W'($urandom_range(0, 3)));
         write_register(CSR_WINDOW_LENGTH, n_len);
         last_pos = (n_len == 0) ? 12'd0 : n_len - 12'd1;
         pos = frame_pos;
         for (int k = 0; k < 50; k++) begin
            // Mostly well-formed frames; now and then a stray frame_end bit.
            fe = ($urandom_range(0, 9) == 0) ? 1'($urandom) : (pos >= last_pos);
            r.sample = random_sample();
            r.frame_end = fe;
            send_sample(r, 1'b0, '0);
            pos = (fe || pos >= last_pos) ? 12'd0 : pos + 12'd1;
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      wait (pending_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS window_coefficient_apply_core");
      end else begin
         $display("FAIL window_coefficient_apply_core");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/wca_pkg.sv
sv/wca_ctrl.sv
sv/wca_datapath.sv
sv/window_coefficient_apply_core.sv
sv/wca_checker.sv
tb/sv/window_coefficient_apply_core_tb.sv
